/* rtl/strided_tap_fir_filter_macros.svh */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter assertion macros
// Concurrent assertion wrappers shared by the filter modules. They sample on
// the clock named clock and are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef STRIDED_TAP_FIR_FILTER_MACROS_SVH
`define STRIDED_TAP_FIR_FILTER_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define STF_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("strided tap filter: assertion failed");
// Check that a trigger is followed by a result in the next cycle
`define STF_ASSERT_NEXT(label, trig, result) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (result)) \
      else $error("strided tap filter: assertion failed");
`else
`define STF_ASSERT(label, prop)
`define STF_ASSERT_NEXT(label, trig, result)
`endif
`endif

/* rtl/stf_pkg.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter package
// Sizes, register indexes, reset values and shared types of the filter.
// ----------------------------------------------------------------------------
package stf_pkg;

   // Delay line geometry
   localparam int MAX_SPACING = 256;
   localparam int NUM_TAPS    = 8;
   localparam int COEF_PAIRS  = NUM_TAPS / 2;
   localparam int HIST_DEPTH  = (NUM_TAPS - 1) * MAX_SPACING + 1;
   localparam int ADDR_W      = $clog2(HIST_DEPTH);
   localparam int COUNT_W     = $clog2(HIST_DEPTH + 1);

   // Field widths
   localparam int SAMPLE_W    = 16;
   localparam int COEF_W      = 16;
   localparam int SPACING_W   = 9;
   localparam int SPC_EFF_W   = $clog2(MAX_SPACING + 1);
   localparam int CLAMP_W     = (SPACING_W > SPC_EFF_W) ? SPACING_W : SPC_EFF_W;

   // Arithmetic
   localparam int FRAC_BITS   = 14;
   localparam int PROD_W      = SAMPLE_W + COEF_W;
   localparam int PAIR_W      = PROD_W + 1;
   localparam int SUM_W       = PROD_W + $clog2(NUM_TAPS);
   localparam int OUT_MAX     = 2 ** (SAMPLE_W - 1) - 1;
   localparam int OUT_MIN     = -(2 ** (SAMPLE_W - 1));

   // Configuration port
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CSR_IDX_W-1:0] REG_TAP_SPACING = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_COEF_PAIR_3 = 3'd4;

   localparam logic [SPACING_W-1:0]  TAP_SPACING_RESET = 9'd1;
   localparam logic [CSR_DATA_W-1:0] COEF_PAIR_0_RESET = 32'd16384;
   localparam logic [CSR_DATA_W-1:0] COEF_PAIR_N_RESET = 32'd0;

   typedef logic [NUM_TAPS-1:0][SAMPLE_W-1:0] tap_vec_type;
   typedef logic [NUM_TAPS-1:0][COEF_W-1:0]   coef_vec_type;

   // Settings seen by the datapath
   typedef struct packed {
      logic [SPC_EFF_W-1:0] spacing;
      coef_vec_type         coef;
   } cfg_type;

   // Tap samples of one transaction, toward the multiply stages
   typedef struct packed {
      logic        valid;
      tap_vec_type taps;
   } tap_bus_type;

endpackage

/* rtl/stf_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module stf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1793
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/stf_csr.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter configuration registers
// Holds tap spacing and coefficient pairs, and clamps the spacing.
// ----------------------------------------------------------------------------
module stf_csr import stf_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [SPACING_W-1:0]  spacing_ff;
   logic [CSR_DATA_W-1:0] coef_pair_ff [COEF_PAIRS];
   logic [CLAMP_W-1:0]    spacing_wide;

   // Register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff      <= TAP_SPACING_RESET;
         coef_pair_ff[0] <= COEF_PAIR_0_RESET;
         coef_pair_ff[1] <= COEF_PAIR_N_RESET;
         coef_pair_ff[2] <= COEF_PAIR_N_RESET;
         coef_pair_ff[3] <= COEF_PAIR_N_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            REG_TAP_SPACING: spacing_ff      <= csr_wdata[SPACING_W-1:0];
            REG_COEF_PAIR_0: coef_pair_ff[0] <= csr_wdata;
            REG_COEF_PAIR_1: coef_pair_ff[1] <= csr_wdata;
            REG_COEF_PAIR_2: coef_pair_ff[2] <= csr_wdata;
            REG_COEF_PAIR_3: coef_pair_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp spacing into one to the maximum, split pairs into taps
   always_comb begin
      spacing_wide = CLAMP_W'(spacing_ff);
      if (spacing_wide == '0) begin
         cfg.spacing = SPC_EFF_W'(1);
      end else if (spacing_wide > CLAMP_W'(MAX_SPACING)) begin
         cfg.spacing = SPC_EFF_W'(MAX_SPACING);
      end else begin
         cfg.spacing = SPC_EFF_W'(spacing_wide);
      end
      for (int j = 0; j < COEF_PAIRS; j++) begin
         cfg.coef[2*j]   = coef_pair_ff[j][COEF_W-1:0];
         cfg.coef[2*j+1] = coef_pair_ff[j][2*COEF_W-1:COEF_W];
      end
   end

endmodule

/* rtl/stf_hist.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter sample history
// Keeps the write position and record fill count, stores each sample into
// one history RAM per delayed tap and reads the spaced taps back.
// ----------------------------------------------------------------------------
`include "strided_tap_fir_filter_macros.svh"

module stf_hist import stf_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       req_record_start,
   input  cfg_type                    cfg,
   input  logic                       mac_stall,
   output tap_bus_type                tap_bus
);

   logic [ADDR_W-1:0]   wp_ff;
   logic [ADDR_W-1:0]   wp_in;
   logic [COUNT_W-1:0]  fill_ff;
   logic [COUNT_W-1:0]  fill_in;
   logic [COUNT_W-1:0]  fill_base;
   logic [COUNT_W-1:0]  fill_need;
   logic                produce;
   logic                take;
   logic                accept;
   logic                tap_valid_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [ADDR_W-1:0]   tap_offset [1:NUM_TAPS-1];
   logic [ADDR_W-1:0]   rd_addr    [1:NUM_TAPS-1];
   logic [SAMPLE_W-1:0] ram_rd     [1:NUM_TAPS-1];

   // Take a transaction when the tap stage is empty or moves on
   assign take      = !tap_valid_ff || !mac_stall;
   assign req_stall = !take;
   assign accept    = req_valid && take;

   // Advance write position and count samples of the record
   always_comb begin
      wp_in     = (COUNT_W'(wp_ff) == COUNT_W'(HIST_DEPTH - 1)) ? '0 : wp_ff + ADDR_W'(1);
      fill_base = req_record_start ? '0 : fill_ff;
      fill_in   = (fill_base < COUNT_W'(HIST_DEPTH)) ? fill_base + COUNT_W'(1) : fill_base;
      fill_need = COUNT_W'(NUM_TAPS - 1) * COUNT_W'(cfg.spacing) + COUNT_W'(1);
      produce   = (fill_in >= fill_need);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= '0;
         fill_ff <= '0;
      end else if (accept) begin
         wp_ff   <= wp_in;
         fill_ff <= fill_in;
      end
   end

   // Hold the tap stage while the multiply stage is blocked
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_valid_ff <= 1'b0;
      end else if (take) begin
         tap_valid_ff <= req_valid && produce;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         sample_ff <= req_sample;
      end
   end

   // Read address of each delayed tap, wrapped around the history
   always_comb begin
      for (int k = 1; k < NUM_TAPS; k++) begin
         tap_offset[k] = ADDR_W'(k) * ADDR_W'(cfg.spacing);
         if (wp_ff >= tap_offset[k]) begin
            rd_addr[k] = wp_ff - tap_offset[k];
         end else begin
            rd_addr[k] = wp_ff + ADDR_W'(HIST_DEPTH) - tap_offset[k];
         end
      end
   end

   // One history copy per delayed tap
   for (genvar g = 1; g < NUM_TAPS; g++) begin : g_tap_ram
      stf_ram #(
         .WIDTH (SAMPLE_W),
         .DEPTH (HIST_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (accept),
         .wr_addr (wp_ff),
         .wr_data (req_sample),
         .rd_en   (accept),
         .rd_addr (rd_addr[g]),
         .rd_data (ram_rd[g])
      );
   end

   always_comb begin
      tap_bus.valid   = tap_valid_ff;
      tap_bus.taps[0] = sample_ff;
      for (int k = 1; k < NUM_TAPS; k++) begin
         tap_bus.taps[k] = ram_rd[k];
      end
   end

   `STF_ASSERT_NEXT(a_start_fill, accept && req_record_start, fill_ff == COUNT_W'(1))
   `STF_ASSERT(a_wp_range, COUNT_W'(wp_ff) < COUNT_W'(HIST_DEPTH))
   `STF_ASSERT_NEXT(a_tap_hold, tap_valid_ff && mac_stall, tap_valid_ff && $stable(sample_ff))

endmodule

/* rtl/stf_mac.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter multiply and sum
// Multiplies the eight taps by their coefficients, adds the products in
// two registered steps, then scales and saturates the result.
// ----------------------------------------------------------------------------
`include "strided_tap_fir_filter_macros.svh"

module stf_mac import stf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  tap_bus_type                 tap_bus,
   input  cfg_type                     cfg,
   output logic                        mac_stall,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_filtered
);

   logic                       prod_valid_ff;
   logic                       pair_valid_ff;
   logic                       out_valid_ff;
   logic                       take_prod;
   logic                       take_pair;
   logic                       take_out;
   logic signed [PROD_W-1:0]   prod_in  [NUM_TAPS];
   logic signed [PROD_W-1:0]   prod_ff  [NUM_TAPS];
   logic signed [PAIR_W-1:0]   pair_in  [COEF_PAIRS];
   logic signed [PAIR_W-1:0]   pair_ff  [COEF_PAIRS];
   logic signed [SUM_W-1:0]    sum_comb;
   logic signed [SUM_W-1:0]    scaled;
   logic signed [SAMPLE_W-1:0] filt_in;
   logic signed [SAMPLE_W-1:0] filt_ff;

   // Each stage loads when empty or when its content moves on
   assign take_out  = !out_valid_ff || !rsp_stall;
   assign take_pair = !pair_valid_ff || take_out;
   assign take_prod = !prod_valid_ff || take_pair;
   assign mac_stall = !take_prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         pair_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (take_prod) begin
            prod_valid_ff <= tap_bus.valid;
         end
         if (take_pair) begin
            pair_valid_ff <= prod_valid_ff;
         end
         if (take_out) begin
            out_valid_ff <= pair_valid_ff;
         end
      end
   end

   // Multiply each tap by its coefficient
   always_comb begin
      for (int k = 0; k < NUM_TAPS; k++) begin
         prod_in[k] = $signed(tap_bus.taps[k]) * $signed(cfg.coef[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (take_prod) begin
         prod_ff <= prod_in;
      end
   end

   // Add neighboring products
   always_comb begin
      for (int j = 0; j < COEF_PAIRS; j++) begin
         pair_in[j] = PAIR_W'(prod_ff[2*j]) + PAIR_W'(prod_ff[2*j+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (take_pair) begin
         pair_ff <= pair_in;
      end
   end

   // Sum the pairs, drop the fraction toward minus infinity, saturate
   always_comb begin
      sum_comb = '0;
      for (int j = 0; j < COEF_PAIRS; j++) begin
         sum_comb = sum_comb + SUM_W'(pair_ff[j]);
      end
      scaled = sum_comb >>> FRAC_BITS;
      if (scaled > SUM_W'(OUT_MAX)) begin
         filt_in = SAMPLE_W'(OUT_MAX);
      end else if (scaled < SUM_W'(OUT_MIN)) begin
         filt_in = SAMPLE_W'(OUT_MIN);
      end else begin
         filt_in = scaled[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (take_out) begin
         filt_ff <= filt_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_filtered = filt_ff;

   `STF_ASSERT_NEXT(a_prod_load, tap_bus.valid && !mac_stall, prod_valid_ff)
   `STF_ASSERT(a_stall_full, !mac_stall || (prod_valid_ff && pair_valid_ff && out_valid_ff))

endmodule

/* rtl/strided_tap_fir_filter.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter
// Eight-tap FIR filter whose taps sit a programmable number of samples
// apart, with Q2.14 coefficients and a saturated 16-bit output.
//
//   Channel  Direction  Handshake             Payload
//   req      in         req_valid/req_stall   req_sample, req_record_start
//   rsp      out        rsp_valid/rsp_stall   rsp_filtered
//   csr      in         csr_write_en          csr_index, csr_wdata
//
// One transaction is accepted every cycle while req_stall is low; each result
// passes through the tap RAM read, multiply, pair-add and output stages.
// Samples that do not yet fill 7*spacing+1 entries of the record give no result.
// Reset clears pointers, fill count and stage valids; the history RAMs need no
// clearing pass.
// rsp_stall holds the stages; req_stall rises only once all four stages are full.
// ----------------------------------------------------------------------------
module strided_tap_fir_filter import stf_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SAMPLE_W-1:0]  req_sample,
   input  logic                        req_record_start,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_filtered,
   input  logic                        csr_write_en,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   cfg_type     cfg;
   tap_bus_type tap_bus;
   logic        mac_stall;

   // Configuration registers
   stf_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Sample history and tap reads
   stf_hist u_hist (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_record_start (req_record_start),
      .cfg              (cfg),
      .mac_stall        (mac_stall),
      .tap_bus          (tap_bus)
   );

   // Multiply, sum and saturate
   stf_mac u_mac (
      .clock        (clock),
      .reset        (reset),
      .tap_bus      (tap_bus),
      .cfg          (cfg),
      .mac_stall    (mac_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_filtered (rsp_filtered)
   );

endmodule

/* bench/strided_tap_fir_filter_tb.sv */
// ----------------------------------------------------------------------------
// Strided-tap FIR filter testbench
// Drives samples and register writes into the filter and predicts every
// filtered output from its own delay line, spacing and coefficients. Results
// are compared in order. The sender works in bursts, the receiver stalls on
// its own pattern, and one long receiver hold-off backs the block up.
// ----------------------------------------------------------------------------
module strided_tap_fir_filter_tb;
   import stf_pkg::*;

   localparam int HALF_PERIOD     = 6;
   localparam int RESET_CYCLES    = 11;
   localparam int DRAIN_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SMALL_PHASES    = 5;
   localparam int TIMEOUT_UNITS   = 12_000_000;
   localparam int REPORT_LIMIT    = 10;

   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_FIRST = REG_COEF_PAIR_3 + 3'd1;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef logic [COEF_PAIRS-1:0][CSR_DATA_W-1:0] pair_set_type;

   typedef enum int {COEF_FULL, COEF_SMALL, COEF_EDGES} coef_mode_type;

   // Predict filtered outputs and hold them until the block delivers them
   class fir_board_type;
      logic [SAMPLE_W-1:0]   history [HIST_DEPTH];
      int unsigned           wr_pos;
      int unsigned           fill;
      logic [SPACING_W-1:0]  spacing;
      logic [CSR_DATA_W-1:0] coef_pair [COEF_PAIRS];
      logic signed [SAMPLE_W-1:0] filtered_due [$];
      int                    mismatches;

      function new();
         wr_pos     = 0;
         fill       = 0;
         spacing    = TAP_SPACING_RESET;
         coef_pair[0] = COEF_PAIR_0_RESET;
         for (int j = 1; j < COEF_PAIRS; j++) coef_pair[j] = COEF_PAIR_N_RESET;
         mismatches = 0;
      endfunction

      function void note_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_TAP_SPACING: spacing = data[SPACING_W-1:0];
            REG_COEF_PAIR_0: coef_pair[0] = data;
            REG_COEF_PAIR_1: coef_pair[1] = data;
            REG_COEF_PAIR_2: coef_pair[2] = data;
            REG_COEF_PAIR_3: coef_pair[3] = data;
            default: ;
         endcase
      endfunction

      // Store the sample and, once the record spans all taps, predict the output
      function void note_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
         int unsigned eff;
         int unsigned newest;
         int unsigned idx;
         int k;
         longint acc;
         longint y;
         logic signed [SAMPLE_W-1:0] x;
         logic signed [COEF_W-1:0] c;
         eff = spacing;
         if (eff == 0) eff = 1;
         if (eff > MAX_SPACING) eff = MAX_SPACING;
         if (start) fill = 0;
         newest = wr_pos;
         history[newest] = smp;
         wr_pos = (newest + 1) % HIST_DEPTH;
         if (fill < HIST_DEPTH) fill++;
         if (fill < (NUM_TAPS - 1) * eff + 1) return;
         acc = 0;
         for (k = 0; k < NUM_TAPS; k++) begin
            idx = (newest + HIST_DEPTH - k * eff) % HIST_DEPTH;
            x   = history[idx];
            c   = coef_pair[k / 2][(k % 2) * COEF_W +: COEF_W];
            acc += longint'(x) * longint'(c);
         end
         // Arithmetic shift floors, then clamp to 16 bits
         y = acc >>> FRAC_BITS;
         if (y > OUT_MAX) y = OUT_MAX;
         if (y < OUT_MIN) y = OUT_MIN;
         filtered_due.push_back(y[SAMPLE_W-1:0]);
      endfunction

      function void check_filtered(logic signed [SAMPLE_W-1:0] got);
         logic signed [SAMPLE_W-1:0] want;
         if (filtered_due.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected filtered output %0d with nothing pending", got);
            return;
         end
         want = filtered_due.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("filtered mismatch: expected %0d, got %0d", want, got);
         end
      endfunction

      function int pending();
         return filtered_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample;
   logic req_record_start;
   logic rsp_valid;
   logic rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_filtered;
   logic csr_write_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   fir_board_type board = new();

   int burst_left  = 0;
   bit steady_send = 1'b0;
   bit hold_off_req = 1'b0;

   strided_tap_fir_filter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_record_start (req_record_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_filtered     (rsp_filtered),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Observe every transaction and register write at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) board.check_filtered(rsp_filtered);
         if (req_valid && !req_stall) board.note_sample(req_sample, req_record_start);
         if (csr_write_en) board.note_register(csr_index, csr_wdata);
      end
   end

   // Stall the result channel: short random runs, quiet stretches, one long hold-off
   initial begin : rsp_pattern
      int run_left;
      bit level;
      run_left  = 0;
      level     = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            level        = 1'b1;
            run_left     = HOLD_OFF_CYCLES;
            hold_off_req = 1'b0;
         end else if (run_left <= 0) begin
            if ($urandom_range(0, 7) == 0) begin
               level    = 1'b0;
               run_left = $urandom_range(30, 80);
            end else begin
               level    = ($urandom_range(0, 2) == 0);
               run_left = $urandom_range(1, 5);
            end
         end
         rsp_stall <= level;
         run_left--;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_UNITS);
      $display("strided_tap_fir_filter test failed");
      $finish;
   end

   function automatic logic [COEF_W-1:0] pick_coef(coef_mode_type mode);
      logic [COEF_W-1:0] c;
      case (mode)
         COEF_SMALL: c = COEF_W'($urandom_range(0, 4095) - 2048);
         COEF_EDGES: begin
            case ($urandom_range(0, 6))
               0: c = 16'h7FFF;
               1: c = 16'h8000;
               2: c = 16'h0000;
               3: c = 16'h4000;
               4: c = 16'hC000;
               5: c = 16'h0001;
               default: c = 16'hFFFF;
            endcase
         end
         default: c = COEF_W'($urandom);
      endcase
      return c;
   endfunction

   function automatic pair_set_type random_pairs(coef_mode_type mode);
      pair_set_type p;
      for (int j = 0; j < COEF_PAIRS; j++) p[j] = {pick_coef(mode), pick_coef(mode)};
      return p;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      logic signed [SAMPLE_W-1:0] s;
      case ($urandom_range(0, 9))
         0: s = SAMPLE_MAX;
         1: s = SAMPLE_MIN;
         2: s = SAMPLE_W'($urandom_range(0, 2)) - 16'sd1;
         default: s = SAMPLE_W'($urandom);
      endcase
      return s;
   endfunction

   // Present one register write; the caller lowers the enable after the last one
   task automatic csr_put(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(negedge clock);
   endtask

   // Write spacing and all coefficient pairs, optionally a stray index too
   task automatic write_regs(input logic [SPACING_W-1:0] spc, input pair_set_type pairs,
                             input bit stray);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom;
      word[SPACING_W-1:0] = spc;
      csr_put(REG_TAP_SPACING, word);
      csr_put(REG_COEF_PAIR_0, pairs[0]);
      csr_put(REG_COEF_PAIR_1, pairs[1]);
      csr_put(REG_COEF_PAIR_2, pairs[2]);
      csr_put(REG_COEF_PAIR_3, pairs[3]);
      if (stray)
         csr_put(REG_UNUSED_FIRST + CSR_IDX_W'($urandom_range(0, 2)), $urandom);
      csr_write_en <= 1'b0;
   endtask

   // Offer one sample transaction and hold it until accepted
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] smp, input logic start);
      int gap;
      if (!steady_send && burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
         burst_left = $urandom_range(1, 40);
         req_valid        <= 1'b0;
         req_sample       <= SAMPLE_W'($urandom);
         req_record_start <= 1'($urandom_range(0, 1));
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_valid        <= 1'b1;
      req_sample       <= smp;
      req_record_start <= start;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain: wait for all pending outputs, then let the pipeline empty
   task automatic settle();
      int quiet;
      quiet = 0;
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      while (quiet < DRAIN_CYCLES) begin
         @(negedge clock);
         if (!rsp_stall) quiet++;
      end
   endtask

   initial begin : stimulus
      pair_set_type pairs;
      logic [SPACING_W-1:0] spc;
      coef_mode_type mode;
      int count;
      int phase;
      int i;
      bit noisy;
      bit start;
      req_valid        = 1'b0;
      req_sample       = '0;
      req_record_start = 1'b0;
      csr_write_en     = 1'b0;
      csr_index        = '0;
      csr_wdata        = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Zero spacing with maximum coefficients: saturate high, then low
      pairs = {COEF_PAIRS{32'h7FFF_7FFF}};
      write_regs('0, pairs, 1'b1);
      send_sample(SAMPLE_MAX, 1'b1);
      repeat (7) send_sample(SAMPLE_MAX, 1'b0);
      repeat (8) send_sample(SAMPLE_MIN, 1'b0);

      // One-LSB tap 0: check flooring of small negative sums
      settle();
      pairs = '0;
      pairs[0] = 32'h0000_0001;
      write_regs(9'd1, pairs, 1'b0);
      send_sample(-16'sd1, 1'b1);
      repeat (6) send_sample(16'sd0, 1'b0);
      send_sample(-16'sd1, 1'b0);
      send_sample(16'sd1, 1'b0);
      send_sample(SAMPLE_MIN, 1'b0);

      // Small spacings, mixed coefficient styles, records restarted or carried over
      for (phase = 0; phase < SMALL_PHASES; phase++) begin
         settle();
         case ($urandom_range(0, 5))
            0: spc = '0;
            1: spc = 9'd1;
            default: spc = SPACING_W'($urandom_range(2, 8));
         endcase
         if (phase == 1) spc = 9'd1;
         case ($urandom_range(0, 3))
            0: mode = COEF_FULL;
            2: mode = COEF_EDGES;
            default: mode = COEF_SMALL;
         endcase
         write_regs(spc, random_pairs(mode), 1'($urandom_range(0, 1)));
         noisy = (phase != 1) && ($urandom_range(0, 4) == 0);
         count = (phase == 1) ? 80 : $urandom_range(50, 90);
         for (i = 0; i < count; i++) begin
            // Back up the block: receiver holds off while samples keep coming
            if (phase == 1 && i == 20) begin
               steady_send  = 1'b1;
               hold_off_req = 1'b1;
            end
            if (phase == 1 && i == 60) steady_send = 1'b0;
            if (i == 0) start = 1'($urandom_range(0, 1));
            else start = ($urandom_range(0, noisy ? 5 : 63) == 0);
            send_sample(random_sample(), start);
         end
      end

      // Spacing above the maximum: one full-depth record
      settle();
      spc = ($urandom_range(0, 1) == 0) ? 9'h1FF
                                        : SPACING_W'($urandom_range(MAX_SPACING + 1, 511));
      write_regs(spc, random_pairs(COEF_SMALL), 1'b1);
      for (i = 0; i < HIST_DEPTH + 40; i++) send_sample(random_sample(), i == 0);

      // Maximum spacing, carried over the already full record
      settle();
      write_regs(SPACING_W'(MAX_SPACING), random_pairs(COEF_FULL), 1'b0);
      for (i = 0; i < 40; i++) send_sample(random_sample(), 1'b0);

      settle();
      if (board.mismatches == 0 && board.pending() == 0)
         $display("strided_tap_fir_filter test passed");
      else
         $display("strided_tap_fir_filter test failed");
      $finish;
   end

endmodule
